// ===== hdl/strec_pkg.sv =====
// Shared types, constants and the control program of the trace recorder.
// No dependencies; every other file imports this package.
package strec_pkg;

  localparam int RING_WORDS_DEF     = 512;
  localparam int FILTER_ENTRIES_DEF = 16;

  localparam logic [7:0]  SKIPPED_CALL = 8'd38;
  localparam logic [63:0] END_WORD     = '1;

  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_REM   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_WAIT = 4'd0;
  localparam logic [STEP_W-1:0] ST_EVT  = 4'd1;
  localparam logic [STEP_W-1:0] ST_NUM  = 4'd2;
  localparam logic [STEP_W-1:0] ST_A1   = 4'd3;
  localparam logic [STEP_W-1:0] ST_A2   = 4'd4;
  localparam logic [STEP_W-1:0] ST_A3   = 4'd5;
  localparam logic [STEP_W-1:0] ST_A4   = 4'd6;
  localparam logic [STEP_W-1:0] ST_END  = 4'd7;
  localparam logic [STEP_W-1:0] ST_ADD  = 4'd8;
  localparam logic [STEP_W-1:0] ST_REM  = 4'd9;
  localparam logic [STEP_W-1:0] ST_READ = 4'd10;
  localparam logic [STEP_W-1:0] ST_DONE = 4'd11;

  localparam logic [2:0] WS_NUM = 3'd0;
  localparam logic [2:0] WS_A1  = 3'd1;
  localparam logic [2:0] WS_A2  = 3'd2;
  localparam logic [2:0] WS_A3  = 3'd3;
  localparam logic [2:0] WS_A4  = 3'd4;
  localparam logic [2:0] WS_END = 3'd5;

  localparam logic [2:0] JK_NEXT     = 3'd0;
  localparam logic [2:0] JK_GOTO     = 3'd1;
  localparam logic [2:0] JK_DISPATCH = 3'd2;
  localparam logic [2:0] JK_SKIP     = 3'd3;
  localparam logic [2:0] JK_ARGS     = 3'd4;
  localparam logic [2:0] JK_OUT      = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  call_number;
    logic [63:0] arg_one;
    logic [63:0] arg_two;
    logic [63:0] arg_three;
    logic [63:0] arg_four;
  } strec_in_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  words_stored;
    logic [63:0] word_out;
    logic        word_valid;
    logic        ring_full;
  } strec_out_t;

  typedef struct packed {
    logic              ring_wr;
    logic [2:0]        wsel;
    logic              ring_rd;
    logic              f_add;
    logic              f_rem;
    logic [2:0]        jmp;
    logic [2:0]        cmp;
    logic [STEP_W-1:0] target;
  } strec_ucw_t;

  typedef struct packed {
    logic       take;
    logic [1:0] op;
    logic       record;
    logic [2:0] nargs;
    logic       out_free;
  } strec_cond_t;

  typedef struct packed {
    logic       ring_wr;
    logic [2:0] wsel;
    logic       ring_rd;
    logic       f_add;
    logic       f_rem;
    logic       in_ready;
    logic       out_load;
  } strec_ctl_t;

  function automatic logic [2:0] arg_count(input logic [7:0] num);
    logic [2:0] n;
    n = 3'd0;
    if (num inside {8'd1, 8'd6, 8'd7, 8'd12, 8'd14, 8'd19, 8'd27, 8'd29, 8'd36})
      n = 3'd1;
    else if (num inside {8'd4, 8'd8, 8'd9, 8'd17, 8'd28, 8'd37, 8'd40})
      n = 3'd2;
    else if (num inside {8'd5, 8'd18, 8'd24, 8'd25, 8'd30, 8'd39, 8'd41})
      n = 3'd3;
    else if (num inside {8'd16, 8'd23, 8'd35})
      n = 3'd4;
    return n;
  endfunction

  function automatic strec_ucw_t ucode(input logic [STEP_W-1:0] step);
    strec_ucw_t w;
    w = '0;
    case (step)
      ST_WAIT: w.jmp = JK_DISPATCH;
      ST_EVT: begin
        w.jmp = JK_SKIP; w.target = ST_DONE;
      end
      ST_NUM: begin
        w.ring_wr = 1'b1; w.wsel = WS_NUM;
        w.jmp = JK_ARGS; w.cmp = 3'd0; w.target = ST_END;
      end
      ST_A1: begin
        w.ring_wr = 1'b1; w.wsel = WS_A1;
        w.jmp = JK_ARGS; w.cmp = 3'd1; w.target = ST_END;
      end
      ST_A2: begin
        w.ring_wr = 1'b1; w.wsel = WS_A2;
        w.jmp = JK_ARGS; w.cmp = 3'd2; w.target = ST_END;
      end
      ST_A3: begin
        w.ring_wr = 1'b1; w.wsel = WS_A3;
        w.jmp = JK_ARGS; w.cmp = 3'd3; w.target = ST_END;
      end
      ST_A4: begin
        w.ring_wr = 1'b1; w.wsel = WS_A4; w.jmp = JK_NEXT;
      end
      ST_END: begin
        w.ring_wr = 1'b1; w.wsel = WS_END;
        w.jmp = JK_GOTO; w.target = ST_DONE;
      end
      ST_ADD: begin
        w.f_add = 1'b1; w.jmp = JK_GOTO; w.target = ST_DONE;
      end
      ST_REM: begin
        w.f_rem = 1'b1; w.jmp = JK_GOTO; w.target = ST_DONE;
      end
      ST_READ: begin
        w.ring_rd = 1'b1; w.jmp = JK_GOTO; w.target = ST_DONE;
      end
      ST_DONE: begin
        w.jmp = JK_OUT; w.target = ST_WAIT;
      end
      default: begin
        w.jmp = JK_GOTO; w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input logic [1:0] op);
    logic [STEP_W-1:0] s;
    case (op)
      OP_EVENT: s = ST_EVT;
      OP_ADD:   s = ST_ADD;
      OP_REM:   s = ST_REM;
      OP_READ:  s = ST_READ;
      default:  s = ST_WAIT;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/syscall_trace_recorder.sv =====
// Top level of the syscall trace recorder: item register, word select, output register.
// Depends on strec_pkg, strec_seq, strec_ring and strec_filter.
//
//   channel   valid      stall      payload     notes
//   input     in_valid   in_stall   in_data     strec_in_t, one op per transaction
//   result    out_valid  out_stall  out_data    strec_out_t, one per op
//   config    cfg_we     -          cfg_index,  cfg_data, taken on any cycle
//
// A recorded event writes the call number, its n arguments (n = argument count, 0-4)
// and the end word, one ring write per such step on the single write port of the ring.
// An ignored event skips to the done step; a filter op or read runs its own step, then
// the done step. Reset is synchronous on rst_n, with no clearing pass. A held result
// stalls only the final step; the next transaction may be accepted while it waits.
module syscall_trace_recorder
  import strec_pkg::*;
#(
  parameter int RING_WORDS     = RING_WORDS_DEF,
  parameter int FILTER_ENTRIES = FILTER_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  strec_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output strec_out_t out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  strec_cond_t cond;
  strec_ctl_t  ctl;
  strec_in_t   item_r;
  strec_out_t  out_data_r;
  logic        out_valid_r, out_valid_nxt;
  logic        enable_r, mode_r;
  logic        status_r, rdv_r;
  logic [2:0]  stored_r;
  logic        take, hit, reject, wr_ok, rd_ok, full;
  logic [63:0] wr_word, rd_data;

  assign take      = in_valid && ctl.in_ready;
  assign in_stall  = !ctl.in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    cond.take     = take;
    cond.op       = in_data.op;
    cond.record   = enable_r && (item_r.call_number != SKIPPED_CALL) && (!mode_r || hit);
    cond.nargs    = arg_count(item_r.call_number);
    cond.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    case (ctl.wsel)
      WS_NUM:  wr_word = {56'd0, item_r.call_number};
      WS_A1:   wr_word = item_r.arg_one;
      WS_A2:   wr_word = item_r.arg_two;
      WS_A3:   wr_word = item_r.arg_three;
      WS_A4:   wr_word = item_r.arg_four;
      default: wr_word = END_WORD;
    endcase
  end

  strec_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctl   (ctl)
  );

  strec_ring #(.RING_WORDS(RING_WORDS)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ctl.ring_wr),
    .wr_data (wr_word),
    .rd      (ctl.ring_rd),
    .wr_ok   (wr_ok),
    .rd_ok   (rd_ok),
    .rd_data (rd_data),
    .full    (full)
  );

  strec_filter #(.FILTER_ENTRIES(FILTER_ENTRIES)) u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .num    (item_r.call_number),
    .add    (ctl.f_add),
    .rem    (ctl.f_rem),
    .hit    (hit),
    .reject (reject)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_ENABLE) enable_r <= cfg_data;
      if (cfg_index == REG_MODE)   mode_r   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 1'b0;
      stored_r <= 3'd0;
      rdv_r    <= 1'b0;
    end else if (take) begin
      status_r <= 1'b0;
      stored_r <= 3'd0;
      rdv_r    <= 1'b0;
    end else begin
      if (ctl.f_add || ctl.f_rem) status_r <= reject;
      if (wr_ok) stored_r <= stored_r + 3'd1;
      if (ctl.ring_rd) rdv_r <= rd_ok;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load)   out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.status       <= status_r;
      out_data_r.words_stored <= stored_r;
      out_data_r.word_out     <= rdv_r ? rd_data : 64'd0;
      out_data_r.word_valid   <= rdv_r;
      out_data_r.ring_full    <= full;
    end
  end

endmodule

// ===== hdl/strec_seq.sv =====
// Step counter and control store of the trace recorder.
// Depends on strec_pkg for the control program and condition types.
module strec_seq
  import strec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  strec_cond_t cond,
  output strec_ctl_t  ctl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  strec_ucw_t        cw;

  assign cw = ucode(step_r);

  always_comb begin
    ctl.ring_wr  = cw.ring_wr;
    ctl.wsel     = cw.wsel;
    ctl.ring_rd  = cw.ring_rd;
    ctl.f_add    = cw.f_add;
    ctl.f_rem    = cw.f_rem;
    ctl.in_ready = (cw.jmp == JK_DISPATCH);
    ctl.out_load = (cw.jmp == JK_OUT) && cond.out_free;
  end

  always_comb begin
    step_nxt = step_r + 1'b1;
    case (cw.jmp)
      JK_NEXT:     step_nxt = step_r + 1'b1;
      JK_GOTO:     step_nxt = cw.target;
      JK_DISPATCH: step_nxt = cond.take ? dispatch(cond.op) : step_r;
      JK_SKIP:     step_nxt = cond.record ? step_r + 1'b1 : cw.target;
      JK_ARGS:     step_nxt = (cond.nargs <= cw.cmp) ? cw.target : step_r + 1'b1;
      JK_OUT:      step_nxt = cond.out_free ? cw.target : step_r;
      default:     step_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/strec_ring.sv =====
// Ring memory of 64-bit trace words with read and write indices and full mark.
// Depends on strec_pkg.
module strec_ring
  import strec_pkg::*;
#(
  parameter int RING_WORDS = RING_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr,
  input  logic [63:0] wr_data,
  input  logic        rd,
  output logic        wr_ok,
  output logic        rd_ok,
  output logic [63:0] rd_data,
  output logic        full
);

  localparam int IDX_W = $clog2(RING_WORDS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_WORDS - 1);

  logic [63:0]      mem [RING_WORDS];
  logic [IDX_W-1:0] wi_r, wi_nxt, ri_r, ri_nxt;
  logic             full_r, full_nxt;
  logic [IDX_W-1:0] wi_inc, ri_inc;
  logic [63:0]      rd_data_r;

  assign wi_inc  = (wi_r == LAST) ? '0 : wi_r + 1'b1;
  assign ri_inc  = (ri_r == LAST) ? '0 : ri_r + 1'b1;
  assign wr_ok   = wr && !full_r;
  assign rd_ok   = rd && ((ri_r != wi_r) || full_r);
  assign rd_data = rd_data_r;
  assign full    = full_r;

  always_comb begin
    wi_nxt   = wi_r;
    ri_nxt   = ri_r;
    full_nxt = full_r;
    if (wr_ok) begin
      wi_nxt = wi_inc;
      if (wi_inc == ri_r) full_nxt = 1'b1;
    end
    if (rd_ok) begin
      ri_nxt   = ri_inc;
      full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r   <= '0;
      ri_r   <= '0;
      full_r <= 1'b0;
    end else begin
      wi_r   <= wi_nxt;
      ri_r   <= ri_nxt;
      full_r <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) mem[wi_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd) rd_data_r <= mem[ri_r];
  end

endmodule

// ===== hdl/strec_filter.sv =====
// Filter set of call numbers: match, add into lowest free slot, remove.
// Depends on strec_pkg.
module strec_filter
  import strec_pkg::*;
#(
  parameter int FILTER_ENTRIES = FILTER_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] num,
  input  logic       add,
  input  logic       rem,
  output logic       hit,
  output logic       reject
);

  localparam int FIDX_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;

  logic [7:0]                ids_r [FILTER_ENTRIES];
  logic [FILTER_ENTRIES-1:0] vld_r, vld_nxt;
  logic [FILTER_ENTRIES-1:0] hit_vec;
  logic [FIDX_W-1:0]         free_idx;
  logic                      any_free;

  always_comb begin
    for (int i = 0; i < FILTER_ENTRIES; i++) begin
      hit_vec[i] = vld_r[i] && (ids_r[i] == num);
    end
  end

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = FILTER_ENTRIES - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_idx = FIDX_W'(i);
        any_free = 1'b1;
      end
    end
  end

  assign hit    = |hit_vec;
  assign reject = add ? (hit || !any_free) : !hit;

  always_comb begin
    vld_nxt = vld_r;
    if (add && !hit && any_free) vld_nxt[free_idx] = 1'b1;
    if (rem) vld_nxt = vld_r & ~hit_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (add && !hit && any_free) ids_r[free_idx] <= num;
  end

endmodule
